// ===== hw/rtl/ucd_pkg.sv =====
// ucd_pkg: shared types, constants and lookup functions for the contention delay block
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package ucd_pkg;

    localparam int UCD_FT_W     = 20;
    localparam int UCD_FPT_W    = 16;
    localparam int UCD_CPL_W    = 9;
    localparam int UCD_LEFT_W   = 8;
    localparam int UCD_SCR_W    = 8;
    localparam int UCD_EXTRA_W  = 3;
    localparam int UCD_CFG_W    = 16;
    localparam int UCD_CFG_IDX_W = 3;

    localparam int UCD_BORDER_LINES   = 24;
    localparam int UCD_SCREEN_LINES   = 192;
    localparam int UCD_BORDER_COLUMNS = 4;
    localparam int UCD_COL_OFFSET     = UCD_BORDER_COLUMNS * 4;
    localparam int UCD_LINE_END       = UCD_BORDER_LINES + UCD_SCREEN_LINES;

    // signed span of frame time minus first pixel time
    localparam int UCD_SPAN_W = UCD_FT_W + 1;
    // in-screen dividend and shifted divisor fit here
    localparam int UCD_REM_W  = 17;
    localparam int UCD_LO_W   = 14;
    localparam int UCD_DIV_STEPS = 9;

    localparam logic [UCD_FPT_W-1:0]  UCD_RST_FIRST_PIXEL = 16'd8944;
    localparam logic [UCD_CPL_W-1:0]  UCD_RST_LINE_LEN    = 9'd224;
    localparam logic [UCD_LEFT_W-1:0] UCD_RST_LEFT        = 8'd24;
    localparam logic [UCD_SCR_W-1:0]  UCD_RST_SCREEN      = 8'd128;
    localparam logic                  UCD_RST_PATTERN     = 1'b0;

    typedef enum logic [UCD_CFG_IDX_W-1:0] {
        CFG_FIRST_PIXEL = 3'd0,
        CFG_LINE_LEN    = 3'd1,
        CFG_LEFT        = 3'd2,
        CFG_SCREEN      = 3'd3,
        CFG_PATTERN     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                 in_range;
        logic [UCD_REM_W-1:0] rem;
        logic [UCD_REM_W-1:0] dvs;
    } t_div;

    function automatic logic [UCD_EXTRA_W-1:0] ucd_pattern(input logic sel,
                                                           input logic [2:0] idx);
        logic [UCD_EXTRA_W-1:0] v;
        if (sel) begin
            case (idx)
                3'd0:    v = 3'd0;
                3'd1:    v = 3'd7;
                3'd2:    v = 3'd6;
                3'd3:    v = 3'd5;
                3'd4:    v = 3'd4;
                3'd5:    v = 3'd3;
                3'd6:    v = 3'd2;
                default: v = 3'd1;
            endcase
        end else begin
            case (idx)
                3'd0:    v = 3'd5;
                3'd1:    v = 3'd4;
                3'd2:    v = 3'd3;
                3'd3:    v = 3'd2;
                3'd4:    v = 3'd1;
                3'd5:    v = 3'd0;
                3'd6:    v = 3'd0;
                default: v = 3'd6;
            endcase
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ucd_in_if.sv =====
// ucd_in_if: input channel carrying one frame time word
// depends on ucd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ucd_in_if;
    logic                          valid;
    logic                          ready;
    logic [ucd_pkg::UCD_FT_W-1:0]  frame_time;

    modport source (output valid, output frame_time, input ready);
    modport sink   (input valid, input frame_time, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ucd_out_if.sv =====
// ucd_out_if: output channel carrying one contention delay word
// depends on ucd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ucd_out_if;
    logic                            valid;
    logic                            ready;
    logic [ucd_pkg::UCD_EXTRA_W-1:0] extra_cycles;

    modport source (output valid, output extra_cycles, input ready);
    modport sink   (input valid, input extra_cycles, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ula_contention_delay.sv =====
// ula_contention_delay: a new frame time word is taken every clock unless a stalled
// output has filled the pipeline; its wait cycle count passes two front stages (span, line range),
// nine one-bit remainder stages for the line position and one output stage. every
// stage has its own valid bit and ready, so bubbles close up under output stall.
// config registers: 0 first pixel time, 1 cycles per line, 2 left border cycles,
// 3 screen cycles, 4 pattern select; write only while no word is in flight.
// depends on ucd_pkg, ucd_in_if, ucd_out_if, ucd_front, ucd_mod_step, ucd_back
`timescale 1ns / 1ps
`default_nettype none

module ula_contention_delay (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    ucd_in_if.sink                                     i_ft_ch,
    ucd_out_if.source                                  o_dly_ch,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ucd_pkg::UCD_CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ucd_pkg::UCD_CFG_W-1:0]         i_cfg_data
);

    logic [ucd_pkg::UCD_FPT_W-1:0]  r_first_pixel;
    logic [ucd_pkg::UCD_CPL_W-1:0]  r_line_len;
    logic [ucd_pkg::UCD_LEFT_W-1:0] r_left;
    logic [ucd_pkg::UCD_SCR_W-1:0]  r_screen;
    logic                           r_pattern;

    logic          s_valid [0:ucd_pkg::UCD_DIV_STEPS];
    logic          s_ready [0:ucd_pkg::UCD_DIV_STEPS];
    ucd_pkg::t_div s_data  [0:ucd_pkg::UCD_DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pixel <= ucd_pkg::UCD_RST_FIRST_PIXEL;
            r_line_len    <= ucd_pkg::UCD_RST_LINE_LEN;
            r_left        <= ucd_pkg::UCD_RST_LEFT;
            r_screen      <= ucd_pkg::UCD_RST_SCREEN;
            r_pattern     <= ucd_pkg::UCD_RST_PATTERN;
        end else if (i_cfg_we) begin
            case (ucd_pkg::t_cfg_idx'(i_cfg_idx))
                ucd_pkg::CFG_FIRST_PIXEL: r_first_pixel <= i_cfg_data;
                ucd_pkg::CFG_LINE_LEN:    r_line_len <= i_cfg_data[ucd_pkg::UCD_CPL_W-1:0];
                ucd_pkg::CFG_LEFT:        r_left     <= i_cfg_data[ucd_pkg::UCD_LEFT_W-1:0];
                ucd_pkg::CFG_SCREEN:      r_screen   <= i_cfg_data[ucd_pkg::UCD_SCR_W-1:0];
                ucd_pkg::CFG_PATTERN:     r_pattern  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ucd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_ft_ch.valid),
        .o_ready       (i_ft_ch.ready),
        .i_frame_time  (i_ft_ch.frame_time),
        .i_first_pixel (r_first_pixel),
        .i_line_len    (r_line_len),
        .i_left        (r_left),
        .o_valid       (s_valid[0]),
        .i_ready       (s_ready[0]),
        .o_data        (s_data[0])
    );

    for (genvar g = 0; g < ucd_pkg::UCD_DIV_STEPS; g++) begin : g_step
        ucd_mod_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_data  (s_data[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    ucd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_valid[ucd_pkg::UCD_DIV_STEPS]),
        .o_ready   (s_ready[ucd_pkg::UCD_DIV_STEPS]),
        .i_data    (s_data[ucd_pkg::UCD_DIV_STEPS]),
        .i_left    (r_left),
        .i_screen  (r_screen),
        .i_pattern (r_pattern),
        .o_valid   (o_dly_ch.valid),
        .i_ready   (o_dly_ch.ready),
        .o_extra   (o_dly_ch.extra_cycles)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ucd_front.sv =====
// ucd_front: two pipeline stages, span and line bounds, then line range test
// depends on ucd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ucd_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [ucd_pkg::UCD_FT_W-1:0]      i_frame_time,
    input  wire logic [ucd_pkg::UCD_FPT_W-1:0]     i_first_pixel,
    input  wire logic [ucd_pkg::UCD_CPL_W-1:0]     i_line_len,
    input  wire logic [ucd_pkg::UCD_LEFT_W-1:0]    i_left,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output ucd_pkg::t_div                          o_data
);

    logic                               r_a_valid;
    logic [ucd_pkg::UCD_SPAN_W-1:0]     r_a_span;
    logic [ucd_pkg::UCD_REM_W-1:0]      r_a_t;
    logic [ucd_pkg::UCD_LO_W-1:0]       r_a_lo;
    logic [ucd_pkg::UCD_REM_W-1:0]      r_a_hi;
    logic [ucd_pkg::UCD_SPAN_W-1:0]     n_a_span;
    logic [ucd_pkg::UCD_REM_W-1:0]      n_a_t;
    logic [ucd_pkg::UCD_LO_W-1:0]       n_a_lo;
    logic [ucd_pkg::UCD_REM_W-1:0]      n_a_hi;
    logic                               r_b_valid;
    ucd_pkg::t_div                      r_b_data;
    ucd_pkg::t_div                      n_b_data;
    logic                               ready_a;
    logic                               ready_b;

    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

    always_comb begin
        n_a_span = {1'b0, i_frame_time}
                 - {{(ucd_pkg::UCD_SPAN_W - ucd_pkg::UCD_FPT_W){1'b0}}, i_first_pixel};
        // position offset: left border minus four times the border columns
        n_a_t = n_a_span[ucd_pkg::UCD_REM_W-1:0]
              + {{(ucd_pkg::UCD_REM_W - ucd_pkg::UCD_LEFT_W){1'b0}}, i_left}
              - ucd_pkg::UCD_REM_W'(ucd_pkg::UCD_COL_OFFSET);
        n_a_lo = {{(ucd_pkg::UCD_LO_W - ucd_pkg::UCD_CPL_W){1'b0}}, i_line_len}
               * ucd_pkg::UCD_LO_W'(ucd_pkg::UCD_BORDER_LINES);
        n_a_hi = {{(ucd_pkg::UCD_REM_W - ucd_pkg::UCD_CPL_W){1'b0}}, i_line_len}
               * ucd_pkg::UCD_REM_W'(ucd_pkg::UCD_LINE_END);
    end

    always_comb begin
        n_b_data.in_range = !r_a_span[ucd_pkg::UCD_SPAN_W-1]
            && (r_a_span[ucd_pkg::UCD_SPAN_W-2:0]
                >= {{(ucd_pkg::UCD_SPAN_W - 1 - ucd_pkg::UCD_LO_W){1'b0}}, r_a_lo})
            && (r_a_span[ucd_pkg::UCD_SPAN_W-2:0]
                < {{(ucd_pkg::UCD_SPAN_W - 1 - ucd_pkg::UCD_REM_W){1'b0}}, r_a_hi});
        n_b_data.rem = r_a_t;
        n_b_data.dvs = {i_line_len, {(ucd_pkg::UCD_REM_W - ucd_pkg::UCD_CPL_W){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_a_span <= n_a_span;
            r_a_t    <= n_a_t;
            r_a_lo   <= n_a_lo;
            r_a_hi   <= n_a_hi;
        end
        if (ready_b && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ucd_mod_step.sv =====
// ucd_mod_step: one restoring remainder step, compare, subtract, halve divisor
// depends on ucd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ucd_mod_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ucd_pkg::t_div  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ucd_pkg::t_div       o_data
);

    logic          r_valid;
    ucd_pkg::t_div r_data;
    ucd_pkg::t_div n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.in_range = i_data.in_range;
        n_data.rem      = (i_data.rem >= i_data.dvs) ? (i_data.rem - i_data.dvs)
                                                     : i_data.rem;
        n_data.dvs      = i_data.dvs >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_data))
        else $error("stalled step lost its word");
    a_rem_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_data.rem <= $past(i_data.rem))
        else $error("remainder grew in a step");
    a_dvs_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_data.dvs == ($past(i_data.dvs) >> 1))
        else $error("divisor not halved");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ucd_back.sv =====
// ucd_back: border tests on line position, pattern lookup, output register
// depends on ucd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ucd_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire ucd_pkg::t_div                     i_data,
    input  wire logic [ucd_pkg::UCD_LEFT_W-1:0]    i_left,
    input  wire logic [ucd_pkg::UCD_SCR_W-1:0]     i_screen,
    input  wire logic                              i_pattern,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [ucd_pkg::UCD_EXTRA_W-1:0]        o_extra
);

    logic                                r_valid;
    logic [ucd_pkg::UCD_EXTRA_W-1:0]     r_extra;
    logic [ucd_pkg::UCD_EXTRA_W-1:0]     n_extra;
    logic [ucd_pkg::UCD_CPL_W:0]         pos_p1;
    logic [ucd_pkg::UCD_LEFT_W:0]        right_end;
    logic                                contended;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_extra = r_extra;

    always_comb begin
        pos_p1    = {1'b0, i_data.rem[ucd_pkg::UCD_CPL_W-1:0]} + 1'b1;
        right_end = {1'b0, i_left} + {1'b0, i_screen};
        contended = i_data.in_range
                 && (pos_p1 >= {{(ucd_pkg::UCD_CPL_W + 1 - ucd_pkg::UCD_LEFT_W){1'b0}}, i_left})
                 && (pos_p1 < {{(ucd_pkg::UCD_CPL_W - ucd_pkg::UCD_LEFT_W){1'b0}}, right_end});
        n_extra   = contended ? ucd_pkg::ucd_pattern(i_pattern, i_data.rem[2:0])
                              : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_extra <= n_extra;
        end
    end

endmodule

`default_nettype wire
